// ===== design/trlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trlc_pkg
// Shared constants, types and helpers for the three-rotor letter cipher.
// ----------------------------------------------------------------------------
package trlc_pkg;

    localparam int ALPHABET_SIZE = 26;   // 2 .. 32
    localparam int ROTOR_COUNT   = 3;    // 1 .. 3
    localparam int MAX_ROTORS    = 3;    // offsets always kept for three rotors

    localparam int FIELD_W = 5;          // width of position / value fields
    localparam int POS_W   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    localparam logic [7:0] LOWER_BASE  = 8'd97;
    localparam logic [7:0] UPPER_BASE  = 8'd65;
    localparam int         LETTER_SPAN = 26;
    localparam int         LETTER_LIM  = (ALPHABET_SIZE < LETTER_SPAN) ?
                                         ALPHABET_SIZE : LETTER_SPAN;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_CHAR = 1'b1
    } t_action;

    typedef logic [POS_W-1:0] t_sym;
    typedef t_sym [MAX_ROTORS-1:0] t_offsets;

    // (a + b) mod ALPHABET_SIZE, both operands below ALPHABET_SIZE
    function automatic t_sym add_mod(input t_sym a, input t_sym b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (POS_W+1)'(ALPHABET_SIZE)) begin
            s = s - (POS_W+1)'(ALPHABET_SIZE);
        end
        return s[POS_W-1:0];
    endfunction

endpackage

// ===== design/trlc_rotor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trlc_rotor
// One rotor table: flop storage written one entry a beat, read at
// (index + offset) mod ALPHABET_SIZE.
// ----------------------------------------------------------------------------
module trlc_rotor
    import trlc_pkg::*;
(
    input  logic i_clk,
    input  logic i_wr_en,
    input  t_sym i_wr_pos,
    input  t_sym i_wr_val,
    input  t_sym i_index,
    input  t_sym i_offset,
    output t_sym o_value
);

    // no reset: contents undefined until loaded
    t_sym r_table [ALPHABET_SIZE];
    t_sym w_pos;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_table[i_wr_pos] <= i_wr_val;
        end
    end

    assign w_pos   = add_mod(i_index, i_offset);
    assign o_value = r_table[w_pos];

endmodule

// ===== design/trlc_odometer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trlc_odometer
// Rotor offsets; first steps per letter, each carries into the next on wrap.
// ----------------------------------------------------------------------------
module trlc_odometer
    import trlc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    output t_offsets o_offsets
);

    localparam t_sym LAST = POS_W'(ALPHABET_SIZE - 1);

    t_offsets r_off;
    t_offsets n_off;

    always_comb begin
        logic carry;
        n_off = r_off;
        carry = i_step;
        for (int k = 0; k < MAX_ROTORS; k++) begin
            if (carry) begin
                if (r_off[k] == LAST) begin
                    n_off[k] = '0;
                end else begin
                    n_off[k] = r_off[k] + t_sym'(1);
                    carry    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
        end else begin
            r_off <= n_off;
        end
    end

    assign o_offsets = r_off;

    // second offset only moves on a wrap of the first
    a_second_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_off[0] != LAST) |=> (r_off[1] == $past(r_off[1])))
        else $error("second offset moved without wrap of the first");

    // no step, no movement
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> (r_off == $past(r_off)))
        else $error("offsets moved without a step");

endmodule

// ===== design/three_rotor_letter_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_rotor_letter_cipher
// Three-rotor substitution cipher for an ASCII byte stream.
// ----------------------------------------------------------------------------
// Every slave beat is either a rotor table load (tuser = 0) or a character
// (tuser = 1). Loads write one entry of one rotor and give no master beat;
// characters give exactly one master beat each, in order. A letter of either
// case runs through rotors 0, 1 and 2, each read at (index + its offset)
// mod 26, and comes out in the same case; the offsets then step like an
// odometer. Other bytes pass unchanged and leave the offsets alone. Load the
// tables before sending letters: an unloaded entry reads as garbage. Entry
// values above 25 are stored as 25; loads to rotor 3 or position 26 and up
// are dropped. One beat a cycle is sustained while the master side accepts
// beats; a character goes from the slave beat through the input register, the
// three chained table reads and the result register to the master beat.
// ----------------------------------------------------------------------------
module three_rotor_letter_cipher
    import trlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [1:0] rotor_select, [6:2] entry_position, [11:7] entry_value,
    // [19:12] char_in, [23:20] zero
    input  logic [23:0] i_s_tdata,
    // [0] action
    input  logic        i_s_tuser,
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] char_out
    output logic [7:0]  o_m_tdata
);

    // ---------------- input register ----------------
    logic               r_s1_valid;
    t_action            r_s1_act;
    logic [1:0]         r_s1_sel;
    logic [FIELD_W-1:0] r_s1_pos;
    logic [FIELD_W-1:0] r_s1_val;
    logic [7:0]         r_s1_char;

    // ---------------- result register ----------------
    logic               r_out_valid;
    logic [7:0]         r_out_char;

    logic w_adv;       // stage-1 beat leaves this cycle
    logic w_in_acc;
    logic w_is_char;
    logic w_lower;
    logic w_upper;
    logic w_letter;
    logic w_pos_ok;
    t_sym w_wr_pos;
    t_sym w_wr_val;
    t_sym w_idx;
    logic [7:0] w_base;
    logic [7:0] w_char_out;
    t_offsets   w_off;
    t_sym       w_chain [ROTOR_COUNT+1];

    assign w_is_char = (r_s1_act == ACT_CHAR);

    // a load never needs the output register; a character needs it free
    assign w_adv = r_s1_valid && (!w_is_char || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_adv;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_act  <= t_action'(i_s_tuser);
            r_s1_sel  <= i_s_tdata[1:0];
            r_s1_pos  <= i_s_tdata[6:2];
            r_s1_val  <= i_s_tdata[11:7];
            r_s1_char <= i_s_tdata[19:12];
        end
    end

    // ---------------- load path ----------------
    assign w_pos_ok = ({1'b0, r_s1_pos} < (FIELD_W+1)'(ALPHABET_SIZE));
    assign w_wr_pos = r_s1_pos[POS_W-1:0];
    // saturate oversized values to the last letter
    assign w_wr_val = ({1'b0, r_s1_val} >= (FIELD_W+1)'(ALPHABET_SIZE)) ?
                      POS_W'(ALPHABET_SIZE - 1) : r_s1_val[POS_W-1:0];

    // ---------------- letter classification ----------------
    assign w_lower  = (r_s1_char >= LOWER_BASE) &&
                      ((r_s1_char - LOWER_BASE) < 8'(LETTER_LIM));
    assign w_upper  = (r_s1_char >= UPPER_BASE) &&
                      ((r_s1_char - UPPER_BASE) < 8'(LETTER_LIM));
    assign w_letter = w_lower || w_upper;
    assign w_base   = w_lower ? LOWER_BASE : UPPER_BASE;
    assign w_idx    = POS_W'(r_s1_char - w_base);

    // ---------------- rotor chain ----------------
    assign w_chain[0] = w_idx;

    for (genvar g = 0; g < ROTOR_COUNT; g++) begin : g_rotor
        logic w_wr_en;
        assign w_wr_en = w_adv && !w_is_char && w_pos_ok && (r_s1_sel == 2'(g));

        trlc_rotor u_rotor (
            .i_clk    (i_clk),
            .i_wr_en  (w_wr_en),
            .i_wr_pos (w_wr_pos),
            .i_wr_val (w_wr_val),
            .i_index  (w_chain[g]),
            .i_offset (w_off[g]),
            .o_value  (w_chain[g+1])
        );
    end

    assign w_char_out = w_letter ? (w_base + 8'(w_chain[ROTOR_COUNT])) : r_s1_char;

    // offsets step once per letter as it leaves stage 1
    trlc_odometer u_odometer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv && w_is_char && w_letter),
        .o_offsets (w_off)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_is_char) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_is_char) begin
            r_out_char <= w_char_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;

    // ---------------- checks ----------------
    // stalled slave side only with a held beat
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && w_is_char && r_out_valid && !i_m_tready))
        else $error("slave side stalled without a blocked character");

    // a load leaving while the result is taken leaves no result behind
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_is_char && r_out_valid && i_m_tready) |=> !r_out_valid)
        else $error("load produced a result beat");

    // non-letters pass through unchanged
    a_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_is_char && !w_letter) |=> (r_out_char == $past(r_s1_char)))
        else $error("non-letter byte altered");

endmodule
